// ----- rtl/mlet_pkg.sv -----
// ----------------------------------------------------------------------------
// mlet_pkg
// Shared types and constants of the maximum line envelope tree.
// ----------------------------------------------------------------------------
package mlet_pkg;

  localparam int NODE_CAP = 4096;
  localparam int IDX_W    = $clog2(NODE_CAP);
  localparam int CNT_W    = IDX_W + 1;
  localparam int COORD_W  = 31;
  localparam int POS_W    = COORD_W + 1;
  localparam int SLOPE_W  = 32;
  localparam int ICPT_W   = 48;
  localparam int VAL_W    = 64;
  localparam int LVL_W    = 6;
  localparam logic [LVL_W-1:0] LEVEL_LIMIT = LVL_W'(COORD_W + 4);
  localparam logic [COORD_W-1:0] DOMAIN_RESET = COORD_W'(2000000000);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POOL_FULL = 2'd1;
  localparam logic [1:0] ST_OUT_RANGE = 2'd2;

  localparam logic [IDX_W-1:0] NO_CHILD = '0;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [ICPT_W-1:0]  icpt;
    logic [IDX_W-1:0]   left;
    logic [IDX_W-1:0]   right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage

// ----- rtl/max_line_envelope_tree_unit.sv -----
// ----------------------------------------------------------------------------
// max_line_envelope_tree_unit
// Maximum line envelope tree with nodes held in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tuser: req_type; tdata: slope, intercept, query_x
//  out_    | master    | tuser: status;   tdata: best_value
//  cfg_    | write     | wdata: domain_top
//
//  One item at a time. Each tree level needs a RAM read (skipped for a
//  freshly allocated node) plus line evaluations through S_MUL and S_ACC on
//  the one shared multiplier: insert six a level, query one, up to 35 levels.
//  Clear and other requests go straight from S_IDLE to S_FIN.
//  After reset the S_INIT state writes the zero root before the first transfer.
//  A result held by a stalled out_ channel blocks the next item only at finish.
// ----------------------------------------------------------------------------
module max_line_envelope_tree_unit
  import mlet_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [111:0]   in_tdata,   // slope[31:0], intercept[79:32], query_x[110:80]
  input  logic [1:0]     in_tuser,   // req_type[1:0]
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_tdata,  // best_value[63:0]
  output logic [1:0]     out_tuser,  // status[1:0]
  input  logic           cfg_we,
  input  logic [30:0]    cfg_wdata   // domain_top[30:0]
);

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_DEC  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [COORD_W-1:0]       domain_r;
  logic                     is_query_r, is_query_nxt;
  logic [COORD_W-1:0]       qx_r, qx_nxt;
  logic signed [SLOPE_W-1:0] ins_slope_r, ins_slope_nxt;
  logic signed [ICPT_W-1:0] ins_icpt_r, ins_icpt_nxt;
  node_t                    node_r, node_nxt;
  logic [IDX_W-1:0]         n_r, n_nxt;
  logic [POS_W-1:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CNT_W-1:0]         used_r, used_nxt;
  logic [LVL_W-1:0]         lvl_r, lvl_nxt;
  logic [2:0]               k_r, k_nxt;
  logic signed [VAL_W-1:0]  prod_r;
  logic signed [VAL_W-1:0]  v_r [6];
  logic signed [VAL_W-1:0]  best_r, best_nxt;
  logic [1:0]               stat_r, stat_nxt;
  logic                     out_valid_r;
  logic [VAL_W-1:0]         out_val_r;
  logic [1:0]               out_stat_r;

  logic                     we, re;
  logic [IDX_W-1:0]         waddr, raddr;
  node_t                    wdata, rdata;

  logic [POS_W-1:0]         mid;
  logic [POS_W-1:0]         x_sel;
  logic signed [SLOPE_W-1:0] a_sel;
  logic signed [ICPT_W-1:0] b_sel;
  logic signed [VAL_W:0]    prod_full;
  logic                     in_xfer;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_stat_r;

  assign mid = POS_W'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  // Select operands of the shared multiplier: even steps stored line, odd new; a query uses the stored line at query_x
  always_comb begin
    a_sel = (k_r[0]) ? ins_slope_r : signed'(node_r.slope);
    b_sel = (k_r[0]) ? ins_icpt_r  : signed'(node_r.icpt);
    case (k_r[2:1])
      2'd0:    x_sel = lo_r;
      2'd1:    x_sel = hi_r;
      default: x_sel = mid;
    endcase
    if (is_query_r) begin
      a_sel = signed'(node_r.slope);
      b_sel = signed'(node_r.icpt);
      x_sel = {1'b0, qx_r};
    end
  end

  assign prod_full = a_sel * signed'({1'b0, x_sel});

  mlet_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer
  always_comb begin
    logic                      swap, go_right, fresh;
    logic signed [VAL_W-1:0]   l_hi, h_hi, l_mid, h_mid;
    logic signed [SLOPE_W-1:0] h_a, l_a;
    logic signed [ICPT_W-1:0]  h_b, l_b;
    logic [IDX_W-1:0]          child;
    node_t                     wr;

    state_nxt     = state_r;
    is_query_nxt  = is_query_r;
    qx_nxt        = qx_r;
    ins_slope_nxt = ins_slope_r;
    ins_icpt_nxt  = ins_icpt_r;
    node_nxt      = node_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    used_nxt      = used_r;
    lvl_nxt       = lvl_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    stat_nxt      = stat_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;
    swap = 1'b0; go_right = 1'b0; fresh = 1'b0;
    l_hi = '0; h_hi = '0; l_mid = '0; h_mid = '0;
    h_a = '0; l_a = '0; h_b = '0; l_b = '0;
    child = '0;
    wr = '0;

    case (state_r)
      S_INIT: begin
        // write the zero root
        we        = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          is_query_nxt  = (in_tuser == REQ_QUERY);
          ins_slope_nxt = signed'(in_tdata[31:0]);
          ins_icpt_nxt  = signed'(in_tdata[79:32]);
          qx_nxt        = in_tdata[110:80];
          best_nxt      = '0;
          stat_nxt      = ST_OK;
          n_nxt         = '0;
          lo_nxt        = '0;
          hi_nxt        = {1'b0, domain_r};
          lvl_nxt       = '0;
          k_nxt         = '0;
          state_nxt     = S_FIN;
          case (in_tuser)
            REQ_INSERT: begin
              re        = 1'b1;
              state_nxt = S_RD;
            end
            REQ_QUERY: begin
              if (in_tdata[110:80] > domain_r) begin
                stat_nxt = ST_OUT_RANGE;
              end else begin
                re        = 1'b1;
                state_nxt = S_RD;
              end
            end
            REQ_CLEAR: begin
              we       = 1'b1;
              used_nxt = CNT_W'(1);
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        node_nxt  = rdata;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (is_query_r || k_r == 3'd5) begin
          state_nxt = S_DEC;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_MUL;
        end
      end
      S_DEC: begin
        lvl_nxt = lvl_r + LVL_W'(1);
        k_nxt   = '0;
        if (is_query_r) begin
          // fold the path maximum and step towards x
          if (v_r[0] > best_r) best_nxt = v_r[0];
          if ({1'b0, qx_r} <= mid) begin
            child  = node_r.left;
            hi_nxt = mid;
          end else begin
            child  = node_r.right;
            lo_nxt = mid + POS_W'(1);
          end
          n_nxt = child;
          if (child == NO_CHILD || lvl_nxt == LEVEL_LIMIT) begin
            state_nxt = S_FIN;
          end else begin
            re        = 1'b1;
            raddr     = child;
            state_nxt = S_RD;
          end
        end else begin
          swap  = v_r[0] > v_r[1];
          l_a   = swap ? ins_slope_r : signed'(node_r.slope);
          l_b   = swap ? ins_icpt_r  : signed'(node_r.icpt);
          h_a   = swap ? signed'(node_r.slope) : ins_slope_r;
          h_b   = swap ? signed'(node_r.icpt)  : ins_icpt_r;
          l_hi  = swap ? v_r[3] : v_r[2];
          h_hi  = swap ? v_r[2] : v_r[3];
          h_mid = swap ? v_r[4] : v_r[5];
          l_mid = swap ? v_r[5] : v_r[4];
          wr    = node_r;
          we    = 1'b1;
          waddr = n_r;
          if (!(l_hi > h_hi)) begin
            // higher line dominates the whole interval
            wr.slope  = h_a;
            wr.icpt   = h_b;
            state_nxt = S_FIN;
          end else begin
            go_right = h_mid > l_mid;
            if (go_right) begin
              wr.slope = h_a;
              wr.icpt  = h_b;
              child    = node_r.right;
              ins_slope_nxt = l_a;
              ins_icpt_nxt  = l_b;
              lo_nxt   = mid + POS_W'(1);
            end else begin
              wr.slope = l_a;
              wr.icpt  = l_b;
              child    = node_r.left;
              ins_slope_nxt = h_a;
              ins_icpt_nxt  = h_b;
              hi_nxt   = mid;
            end
            if (child == NO_CHILD) begin
              if (used_r >= CNT_W'(NODE_CAP)) begin
                stat_nxt = ST_POOL_FULL;
              end else begin
                child    = IDX_W'(used_r);
                used_nxt = used_r + CNT_W'(1);
                fresh    = 1'b1;
                if (go_right) wr.right = child;
                else          wr.left  = child;
              end
            end
            n_nxt = child;
            if (stat_nxt == ST_POOL_FULL || lvl_nxt == LEVEL_LIMIT) begin
              state_nxt = S_FIN;
            end else if (fresh) begin
              // new node starts as the zero line with no children
              node_nxt  = '0;
              state_nxt = S_MUL;
            end else begin
              re        = 1'b1;
              raddr     = child;
              state_nxt = S_RD;
            end
          end
          wdata = wr;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      domain_r    <= DOMAIN_RESET;
      used_r      <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      if (cfg_we) domain_r <= cfg_wdata;
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    is_query_r  <= is_query_nxt;
    qx_r        <= qx_nxt;
    ins_slope_r <= ins_slope_nxt;
    ins_icpt_r  <= ins_icpt_nxt;
    node_r      <= node_nxt;
    n_r         <= n_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    lvl_r       <= lvl_nxt;
    k_r         <= k_nxt;
    best_r      <= best_nxt;
    stat_r      <= stat_nxt;
    if (state_r == S_MUL) prod_r <= prod_full[VAL_W-1:0];
    if (state_r == S_ACC) begin
      v_r[k_r] <= prod_r + VAL_W'(b_sel);
    end
    if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
      out_val_r  <= best_r;
      out_stat_r <= stat_r;
    end
  end

endmodule

// ----- rtl/mlet_ram.sv -----
// ----------------------------------------------------------------------------
// mlet_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mlet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the maximum line envelope tree. A queue-fed driver
// sends insert, query, clear and unused requests over in_; a monitor checks
// every out_ transfer against a predictor of the tree kept in the bench. The
// run steps through several domain settings and idle patterns, and fills the
// node pool until lines are dropped.
// ----------------------------------------------------------------------------
module testbench;
  import mlet_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         req;
    logic [SLOPE_W-1:0] slope;
    logic [ICPT_W-1:0]  icpt;
    logic [COORD_W-1:0] x;
  } request_t;

  typedef struct {
    logic [VAL_W-1:0] best;
    logic [1:0]       status;
  } answer_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [111:0]       in_tdata = '0;   // slope, intercept, query_x, pad bit
  logic [1:0]         in_tuser = '0;   // req_type
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [63:0]        out_tdata;       // best_value
  logic [1:0]         out_tuser;       // status
  logic               cfg_we = 1'b0;
  logic [30:0]        cfg_wdata = '0;  // domain_top

  request_t pending_reqs[$];
  answer_t  due_answers[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       error_count = 0;
  int       quiet_cycles = 0;

  // Bench copy of the tree
  logic [VAL_W-1:0] tree_slope[NODE_CAP];
  logic [VAL_W-1:0] tree_icpt[NODE_CAP];
  int               tree_left[NODE_CAP];
  int               tree_right[NODE_CAP];
  int               tree_used;
  logic [VAL_W-1:0] tree_domain;

  max_line_envelope_tree_unit DUT (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [VAL_W-1:0] line_value(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                                  logic [VAL_W-1:0] x);
    return a * x + b;
  endfunction

  function automatic bit beats(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

  function automatic void tree_clear();
    tree_slope[0] = '0;
    tree_icpt[0]  = '0;
    tree_left[0]  = 0;
    tree_right[0] = 0;
    tree_used     = 1;
  endfunction

  // Allocate a fresh zero-line node, or return -1 when the pool is spent
  function automatic int tree_alloc();
    int idx;
    if (tree_used >= NODE_CAP) return -1;
    idx = tree_used;
    tree_used++;
    tree_slope[idx] = '0;
    tree_icpt[idx]  = '0;
    tree_left[idx]  = 0;
    tree_right[idx] = 0;
    return idx;
  endfunction

  function automatic logic [1:0] tree_insert(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    int n, c, lvl;
    logic [VAL_W-1:0] lo, hi, mid, la, lb, ha, hb, t;
    n = 0;
    lo = '0;
    hi = tree_domain;
    for (lvl = 0; lvl < COORD_W + 4; lvl++) begin
      la = tree_slope[n];
      lb = tree_icpt[n];
      ha = a;
      hb = b;
      // keep the line that is higher at the left end in ha/hb
      if (beats(line_value(la, lb, lo), line_value(ha, hb, lo))) begin
        t = la; la = ha; ha = t;
        t = lb; lb = hb; hb = t;
      end
      if (!beats(line_value(la, lb, hi), line_value(ha, hb, hi))) begin
        tree_slope[n] = ha;
        tree_icpt[n]  = hb;
        return ST_OK;
      end
      mid = (lo + hi) >> 1;
      if (beats(line_value(ha, hb, mid), line_value(la, lb, mid))) begin
        tree_slope[n] = ha;
        tree_icpt[n]  = hb;
        c = tree_right[n];
        if (c == 0) begin
          c = tree_alloc();
          if (c < 0) return ST_POOL_FULL;
          tree_right[n] = c;
        end
        a = la;
        b = lb;
        lo = mid + 1;
      end else begin
        tree_slope[n] = la;
        tree_icpt[n]  = lb;
        c = tree_left[n];
        if (c == 0) begin
          c = tree_alloc();
          if (c < 0) return ST_POOL_FULL;
          tree_left[n] = c;
        end
        a = ha;
        b = hb;
        hi = mid;
      end
      n = c;
    end
    return ST_OK;
  endfunction

  function automatic logic [VAL_W-1:0] tree_max_at(logic [VAL_W-1:0] x);
    int n, lvl;
    logic [VAL_W-1:0] best, lo, hi, mid, v;
    best = '0;
    lo = '0;
    hi = tree_domain;
    n = 0;
    for (lvl = 0; lvl < COORD_W + 4; lvl++) begin
      v = line_value(tree_slope[n], tree_icpt[n], x);
      if (beats(v, best)) best = v;
      mid = (lo + hi) >> 1;
      if (x <= mid) begin
        n = tree_left[n];
        hi = mid;
      end else begin
        n = tree_right[n];
        lo = mid + 1;
      end
      if (n == 0) break;
    end
    return best;
  endfunction

  function automatic answer_t tree_apply(request_t r);
    answer_t ans;
    ans.best = '0;
    ans.status = ST_OK;
    case (r.req)
      REQ_INSERT: begin
        ans.status = tree_insert({{32{r.slope[31]}}, r.slope}, {{16{r.icpt[47]}}, r.icpt});
      end
      REQ_QUERY: begin
        if (64'(r.x) > tree_domain) ans.status = ST_OUT_RANGE;
        else ans.best = tree_max_at(64'(r.x));
      end
      REQ_CLEAR: begin
        tree_clear();
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: predict on each accepted transfer, then offer the next request
  always @(posedge clk) begin
    bit       fire;
    request_t sent_req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        sent_req = pending_reqs.pop_front();
        due_answers = {due_answers, tree_apply(sent_req)};
      end
      if (in_tvalid && !fire) begin
        // hold the offered transfer
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, pending_reqs[0].x, pending_reqs[0].icpt, pending_reqs[0].slope};
        in_tuser  <= pending_reqs[0].req;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_answers.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, '0);
        end else begin
          want = due_answers.pop_front();
          if (out_tdata !== want.best) report_mismatch("best_value", out_tdata, want.best);
          if (out_tuser !== want.status) report_mismatch("status", 64'(out_tuser),
                                                         64'(want.status));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] req, logic [31:0] s, logic [47:0] b, logic [30:0] x);
    request_t r;
    r.req = req;
    r.slope = s;
    r.icpt = b;
    r.x = x;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || due_answers.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_domain(logic [30:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tree_domain = 64'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  task automatic push_random(int count);
    int k, r;
    logic [31:0] s;
    logic [47:0] b;
    logic [30:0] x;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99);
      s = ($urandom_range(1)) ? 32'($urandom) : 32'($signed($urandom_range(2000)) - 1000);
      b = ($urandom_range(1)) ? {16'($urandom), 32'($urandom)}
                              : 48'($signed($urandom_range(200000)) - 100000);
      case ($urandom_range(6))
        0: x = 31'($urandom);
        1: x = (tree_domain < 64'h7fff_ffff) ? 31'(tree_domain + 1) : 31'($urandom);
        default: x = 31'($urandom_range(31'(tree_domain)));
      endcase
      if (r < 50) push_req(REQ_INSERT, s, b, 31'($urandom));
      else if (r < 96) push_req(REQ_QUERY, 32'($urandom), 48'($urandom), x);
      else if (r < 98) push_req(REQ_CLEAR, s, b, x);
      else push_req(REQ_UNUSED, s, b, x);
    end
  endtask

  initial begin
    int ph, t;
    logic [30:0] domains[5];
    tree_clear();
    tree_domain = 64'(DOMAIN_RESET);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tree, field extremes, out-of-domain, unused code, clear
    set_idling(0);
    push_req(REQ_QUERY, '0, '0, '0);
    push_req(REQ_INSERT, 32'h7fff_ffff, 48'h8000_0000_0000, '0);
    push_req(REQ_QUERY, '0, '0, '0);
    push_req(REQ_QUERY, '0, '0, 31'(DOMAIN_RESET));
    push_req(REQ_QUERY, '0, '0, 31'(DOMAIN_RESET) + 31'd1);
    push_req(REQ_QUERY, '1, '1, '1);
    push_req(REQ_INSERT, 32'h8000_0000, 48'h7fff_ffff_ffff, '1);
    push_req(REQ_QUERY, '0, '0, 31'd1000);
    push_req(REQ_QUERY, '0, '0, 31'd1999999999);
    push_req(REQ_UNUSED, '1, '1, '1);
    push_req(REQ_CLEAR, '1, '1, '1);
    push_req(REQ_INSERT, '1, '1, '0);
    push_req(REQ_QUERY, '0, '0, 31'd5);
    push_req(REQ_INSERT, 32'd3, 48'd10, '0);
    push_req(REQ_INSERT, 32'hffff_fffd, 48'd6_000_000_010, '0);
    push_req(REQ_QUERY, '0, '0, 31'd0);
    push_req(REQ_QUERY, '0, '0, 31'd1_000_000_000);
    drain();

    // Smallest domains, zero among them
    write_domain(31'd1);
    push_req(REQ_INSERT, 32'd5, '0, '0);
    push_req(REQ_INSERT, 32'hffff_fffb, 48'd4, '0);
    push_req(REQ_QUERY, '0, '0, 31'd0);
    push_req(REQ_QUERY, '0, '0, 31'd1);
    push_req(REQ_QUERY, '0, '0, 31'd2);
    drain();
    write_domain(31'd0);
    push_req(REQ_INSERT, 32'd7, 48'd3, '0);
    push_req(REQ_QUERY, '0, '0, 31'd0);
    push_req(REQ_QUERY, '0, '0, 31'd1);
    drain();

    // Random phases over several domains and idle patterns
    domains[0] = 31'h7fff_ffff;
    domains[1] = 31'd1000;
    domains[2] = 31'(DOMAIN_RESET);
    domains[3] = 31'd63;
    domains[4] = 31'($urandom);
    for (ph = 0; ph < 8; ph++) begin
      write_domain(domains[ph % 5]);
      set_idling(ph);
      push_random(175);
      drain();
    end

    // Fill the node pool with crossing tangent lines until inserts are dropped
    set_idling(0);
    write_domain(31'd8191);
    push_req(REQ_CLEAR, '0, '0, '0);
    while (tree_used < NODE_CAP) begin
      repeat (100) begin
        t = $urandom_range(8191);
        push_req(REQ_INSERT, 32'(2 * t), 48'(-(longint'(t) * t)), '0);
      end
      drain();
    end
    set_idling(3);
    repeat (20) begin
      t = $urandom_range(8191);
      push_req(REQ_INSERT, 32'(2 * t + 1), 48'(-(longint'(t) * t)), '0);
      push_req(REQ_QUERY, '0, '0, 31'($urandom_range(8191)));
    end
    push_req(REQ_CLEAR, '0, '0, '0);
    push_req(REQ_QUERY, '0, '0, 31'd17);
    drain();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mlet_pkg.sv
rtl/mlet_ram.sv
rtl/max_line_envelope_tree_unit.sv
tb/testbench.sv
